/* rtl/tepq_pkg.sv */
// shared types and constants for the timed event priority queue
`default_nettype none
package tepq_pkg;
    localparam int unsigned TickW  = 64;
    localparam int unsigned SeqW   = 64;
    localparam int unsigned SlotW  = 6;
    localparam int unsigned CountW = 7;
    localparam int unsigned InW    = 136;
    localparam int unsigned OutW   = 280;

    typedef enum logic [1:0] {
        FN_SCHEDULE = 2'd0,
        FN_CANCEL   = 2'd1,
        FN_ADVANCE  = 2'd2,
        FN_UNUSED   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_ARG   = 2'd1,
        ST_BAD_STATE = 2'd2,
        ST_NO_SLOT   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        EM_ERR   = 2'd0,
        EM_OK    = 2'd1,
        EM_FIRE  = 2'd2,
        EM_CLOSE = 2'd3
    } t_emit;

    typedef struct packed {
        logic  load;
        logic  apply;
        logic  scan_start;
        logic  scan_step;
        logic  remove_min;
        logic  emit;
        t_emit kind;
    } t_dp_cmd;

    typedef struct packed {
        t_func   func;
        t_status err;
        logic    scan_last;
        logic    fire_ok;
        logic    out_done;
    } t_dp_stat;
endpackage
`default_nettype wire

/* rtl/tepq_ctrl.sv */
// controller state machine for the timed event priority queue
`default_nettype none
module tepq_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_s_tvalid,
    output logic               o_s_tready,
    input  tepq_pkg::t_dp_stat i_stat,
    output tepq_pkg::t_dp_cmd  o_cmd
);
    import tepq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_SCAN, S_EMIT, S_CHECK, S_WAIT
    } t_state;

    t_state r_state, n_state;
    logic   r_adv, n_adv;
    logic   r_ret, n_ret;

    always_comb begin
        n_state = r_state;
        n_adv   = r_adv;
        n_ret   = r_ret;
        o_cmd   = '0;
        o_cmd.kind = EM_ERR;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.err != ST_OK) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = EM_ERR;
                    n_ret   = 1'b0;
                    n_state = S_WAIT;
                end else if (i_stat.func == FN_ADVANCE) begin
                    n_adv   = 1'b1;
                    n_state = S_CHECK;
                end else begin
                    o_cmd.apply      = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_adv   = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) n_state = S_EMIT;
            end
            // minimum now includes the last slot
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                o_cmd.kind = r_adv ? EM_FIRE : EM_OK;
                n_ret   = r_adv;
                n_state = S_WAIT;
            end
            S_CHECK: begin
                if (i_stat.fire_ok) begin
                    o_cmd.remove_min = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state = S_SCAN;
                end else begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = EM_CLOSE;
                    n_ret   = 1'b0;
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_stat.out_done) n_state = r_ret ? S_CHECK : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_adv   <= 1'b0;
            r_ret   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_adv   <= n_adv;
            r_ret   <= n_ret;
        end
    end
endmodule
`default_nettype wire

/* rtl/tepq_dp.sv */
// datapath: event store, minimum scan and result register
`default_nettype none
module tepq_dp #(
    parameter int unsigned CAPACITY = 16
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire [tepq_pkg::InW-1:0]  i_s_tdata,
    input  wire [1:0]                i_s_tuser,
    input  tepq_pkg::t_dp_cmd        i_cmd,
    output tepq_pkg::t_dp_stat       o_stat,
    output logic                     o_m_tvalid,
    input  wire                      i_m_tready,
    output logic [tepq_pkg::OutW-1:0] o_m_tdata,
    output logic                     o_m_tlast
);
    import tepq_pkg::*;

    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic [TickW-1:0] r_due [CAPACITY];
    logic [SeqW-1:0]  r_seq [CAPACITY];
    logic [CAPACITY-1:0] r_act;
    logic [CW-1:0]    r_cnt;
    logic [SeqW-1:0]  r_issue;
    logic [TickW-1:0] r_now;

    // latched command
    t_func            r_func;
    logic [TickW-1:0] r_tick;
    logic [SlotW-1:0] r_cslot;
    logic [SeqW-1:0]  r_cseq;

    // running minimum
    logic [IW-1:0]    r_idx;
    logic             r_min_valid;
    logic [IW-1:0]    r_min_slot;
    logic [TickW-1:0] r_min_due;
    logic [SeqW-1:0]  r_min_seq;

    // result of the operation
    logic [SlotW-1:0] r_res_slot;
    logic [SeqW-1:0]  r_res_seq;
    logic [TickW-1:0] r_res_due;

    logic [IW-1:0]    free_slot;
    logic [IW-1:0]    cidx;
    logic             cslot_ok;
    t_status          err;
    logic [OutW-1:0]  beat_data;

    always_comb begin
        free_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
            if (!r_act[i]) free_slot = IW'(i);
    end

    assign cslot_ok = (r_cslot < SlotW'(CAPACITY));
    assign cidx     = r_cslot[IW-1:0];

    always_comb begin
        err = ST_OK;
        case (r_func)
            FN_SCHEDULE: begin
                if (r_tick < r_now || r_issue == {SeqW{1'b1}}) err = ST_BAD_ARG;
                else if (r_cnt == CW'(CAPACITY)) err = ST_NO_SLOT;
            end
            FN_CANCEL: begin
                if (!cslot_ok) err = ST_BAD_ARG;
                else if (!r_act[cidx] || r_seq[cidx] != r_cseq) err = ST_BAD_STATE;
            end
            FN_ADVANCE: begin
                if (r_tick < r_now) err = ST_BAD_ARG;
            end
            default: err = ST_BAD_ARG;
        endcase
    end

    assign o_stat.func      = r_func;
    assign o_stat.err       = err;
    assign o_stat.scan_last = (r_idx == IW'(CAPACITY - 1));
    assign o_stat.fire_ok   = r_min_valid && (r_min_due <= r_tick);
    assign o_stat.out_done  = o_m_tvalid && i_m_tready;

    logic take;
    assign take = r_act[r_idx] && (!r_min_valid || r_due[r_idx] < r_min_due ||
                  (r_due[r_idx] == r_min_due && r_seq[r_idx] < r_min_seq));

    always_comb begin
        beat_data = '0;
        beat_data[1:0]     = (i_cmd.kind == EM_ERR) ? err : ST_OK;
        beat_data[2]       = (i_cmd.kind == EM_FIRE);
        beat_data[137]     = r_min_valid;
        beat_data[201:138] = r_min_valid ? r_min_due : '0;
        beat_data[208:202] = CountW'(r_cnt);
        beat_data[272:209] = (i_cmd.kind == EM_CLOSE) ? r_tick : r_now;
        if (i_cmd.kind == EM_OK || i_cmd.kind == EM_FIRE) begin
            beat_data[8:3]  = r_res_slot;
            beat_data[72:9] = r_res_seq;
        end
        if (i_cmd.kind == EM_FIRE) beat_data[136:73] = r_res_due;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= t_func'(i_s_tuser);
            r_tick  <= i_s_tdata[63:0];
            r_cslot <= i_s_tdata[69:64];
            r_cseq  <= i_s_tdata[133:70];
        end
        if (i_cmd.apply && r_func == FN_SCHEDULE) begin
            r_due[free_slot] <= r_tick;
            r_seq[free_slot] <= r_issue;
        end
        if (i_cmd.apply) begin
            r_res_slot <= (r_func == FN_SCHEDULE) ? SlotW'(free_slot) : '0;
            r_res_seq  <= (r_func == FN_SCHEDULE) ? r_issue : '0;
        end
        if (i_cmd.remove_min) begin
            r_res_slot <= SlotW'(r_min_slot);
            r_res_seq  <= r_min_seq;
            r_res_due  <= r_min_due;
        end
        if (i_cmd.emit) begin
            o_m_tlast <= (i_cmd.kind != EM_FIRE);
            o_m_tdata <= beat_data;
        end
        if (i_cmd.scan_start) begin
            r_min_slot <= '0;
            r_min_due  <= '0;
            r_min_seq  <= '0;
        end else if (i_cmd.scan_step && take) begin
            r_min_slot <= r_idx;
            r_min_due  <= r_due[r_idx];
            r_min_seq  <= r_seq[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act       <= '0;
            r_cnt       <= '0;
            r_issue     <= '0;
            r_now       <= '0;
            r_idx       <= '0;
            r_min_valid <= 1'b0;
            o_m_tvalid  <= 1'b0;
        end else begin
            if (i_cmd.apply && r_func == FN_SCHEDULE) begin
                r_act[free_slot] <= 1'b1;
                r_cnt   <= r_cnt + 1'b1;
                r_issue <= r_issue + 1'b1;
            end
            if (i_cmd.apply && r_func == FN_CANCEL) begin
                r_act[cidx] <= 1'b0;
                r_cnt <= r_cnt - 1'b1;
            end
            if (i_cmd.remove_min) begin
                r_act[r_min_slot] <= 1'b0;
                r_cnt <= r_cnt - 1'b1;
                r_now <= r_min_due;
            end
            if (i_cmd.emit && i_cmd.kind == EM_CLOSE) r_now <= r_tick;
            if (i_cmd.scan_start) begin
                r_idx       <= '0;
                r_min_valid <= 1'b0;
            end else if (i_cmd.scan_step) begin
                if (take) r_min_valid <= 1'b1;
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.emit) o_m_tvalid <= 1'b1;
            else if (i_m_tready) o_m_tvalid <= 1'b0;
        end
    end
endmodule
`default_nettype wire

/* rtl/timed_event_priority_queue_top.sv */
// top level of the timed event priority queue
// channel  dir  tdata                                            tuser  tlast
// s        in   tick, cancel_slot, cancel_sequence               func   -
// m        out  status..current_tick (see port)                  -      last
// one beat in at a time; schedule and cancel pass through decode, a
// slot-at-a-time minimum scan and the result beat before the next beat is
// accepted; advance scans once per fired event and ends with a closing beat;
// a rejected item goes straight from decode to its error beat. reset clears
// the pending set, counters and current tick.
// input is not taken again until the last result beat of an item is taken;
// a stalled result holds.
`default_nettype none
module timed_event_priority_queue_top #(
    parameter int unsigned CAPACITY = 16
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_s_tvalid,
    output logic                      o_s_tready,
    // tick[63:0], cancel_slot[69:64], cancel_sequence[133:70]
    input  wire [tepq_pkg::InW-1:0]   i_s_tdata,
    // func[1:0]
    input  wire [1:0]                 i_s_tuser,
    output logic                      o_m_tvalid,
    input  wire                       i_m_tready,
    // status[1:0], event_fired[2], slot[8:3], sequence_res[72:9],
    // fired_due_tick[136:73], next_due_valid[137], next_due_tick[201:138],
    // pending_count[208:202], current_tick[272:209]
    output logic [tepq_pkg::OutW-1:0] o_m_tdata,
    output logic                      o_m_tlast
);
    import tepq_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    tepq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tepq_dp #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );
endmodule
`default_nettype wire

/* rtl/tepq_checker.sv */
// port-level checks for the timed event priority queue
`default_nettype none
module tepq_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         o_s_tready,
    input wire         o_m_tvalid,
    input wire         i_m_tready,
    input wire [279:0] o_m_tdata,
    input wire         o_m_tlast
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid)) else $error("input taken while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result beat changed");
    a_fire_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[2] |-> !o_m_tlast) else $error("fired beat marked last");
    a_next_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[137] == (o_m_tdata[208:202] != 7'd0)))
        else $error("next due flag disagrees with count");
endmodule

bind timed_event_priority_queue_top tepq_checker u_tepq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
`default_nettype wire

/* test/timed_event_priority_queue_top_tb.sv */
// testbench for the timed event priority queue: random commands checked against a heap model
`default_nettype none
module timed_event_priority_queue_top_tb;
    import tepq_pkg::*;

    localparam int unsigned Cap       = 16;
    localparam int unsigned StallLim  = 20000;

    typedef struct packed {
        t_status     status;
        logic        fired;
        logic [5:0]  slot;
        logic [63:0] seq;
        logic [63:0] fdue;
        logic        nd_valid;
        logic [63:0] nd_tick;
        logic [6:0]  pending;
        logic [63:0] cur_tick;
        logic        last;
    } t_result;

    // model of the timer heap and its expected result beats
    class timer_queue_scoreboard;
        logic [63:0] due[Cap];
        logic [63:0] seqs[Cap];
        bit          active[Cap];
        int unsigned pos[Cap];
        int unsigned order[Cap];
        int unsigned count;
        logic [63:0] issue;
        logic [63:0] now;
        t_result     pending_beats[$];
        int          errors;

        function new();
            for (int i = 0; i < Cap; i++) begin
                due[i] = '0; seqs[i] = '0; active[i] = 0; pos[i] = 0; order[i] = 0;
            end
            count = 0; issue = '0; now = '0; errors = 0;
        endfunction

        function bit sooner(int unsigned a, int unsigned b);
            return due[a] < due[b] || (due[a] == due[b] && seqs[a] < seqs[b]);
        endfunction

        function void swap_nodes(int unsigned i, int unsigned j);
            int unsigned t;
            t = order[i]; order[i] = order[j]; order[j] = t;
            pos[order[i]] = i; pos[order[j]] = j;
        endfunction

        function void sift_up(int unsigned i);
            while (i != 0 && i < count) begin
                if (!sooner(order[i], order[(i - 1) / 2])) break;
                swap_nodes(i, (i - 1) / 2);
                i = (i - 1) / 2;
            end
        endfunction

        function void sift_down(int unsigned i);
            int unsigned l, r, m;
            while (i < count) begin
                l = 2 * i + 1; r = l + 1; m = i;
                if (l < count && sooner(order[l], order[m])) m = l;
                if (r < count && sooner(order[r], order[m])) m = r;
                if (m == i) return;
                swap_nodes(i, m);
                i = m;
            end
        endfunction

        function void remove_at(int unsigned i);
            if (i >= count || count == 0) return;
            count--;
            if (i == count) return;
            order[i] = order[count];
            pos[order[i]] = i;
            if (i != 0 && sooner(order[i], order[(i - 1) / 2])) sift_up(i);
            else sift_down(i);
        endfunction

        function void push_beat(t_status st, logic fired, logic [5:0] slot,
                                logic [63:0] seq, logic [63:0] fdue, logic last);
            t_result r;
            r.status = st; r.fired = fired; r.slot = slot; r.seq = seq; r.fdue = fdue;
            r.nd_valid = (count != 0);
            r.nd_tick  = (count != 0) ? due[order[0]] : '0;
            r.pending  = 7'(count);
            r.cur_tick = now;
            r.last     = last;
            pending_beats.push_back(r);
        endfunction

        function void note_command(t_func fn, logic [63:0] tick, logic [5:0] cslot,
                                   logic [63:0] cseq);
            int unsigned s, k;
            case (fn)
                FN_SCHEDULE: begin
                    if (tick < now || issue == '1) begin
                        push_beat(ST_BAD_ARG, 0, '0, '0, '0, 1);
                        return;
                    end
                    for (s = 0; s < Cap; s++) if (!active[s]) break;
                    if (s >= Cap) begin
                        push_beat(ST_NO_SLOT, 0, '0, '0, '0, 1);
                        return;
                    end
                    due[s] = tick; seqs[s] = issue; issue++;
                    active[s] = 1; pos[s] = count; order[count] = s; count++;
                    sift_up(pos[s]);
                    push_beat(ST_OK, 0, 6'(s), seqs[s], '0, 1);
                end
                FN_CANCEL: begin
                    if (cslot >= Cap) push_beat(ST_BAD_ARG, 0, '0, '0, '0, 1);
                    else if (!active[cslot] || seqs[cslot] != cseq)
                        push_beat(ST_BAD_STATE, 0, '0, '0, '0, 1);
                    else begin
                        remove_at(pos[cslot]);
                        active[cslot] = 0;
                        push_beat(ST_OK, 0, '0, '0, '0, 1);
                    end
                end
                FN_ADVANCE: begin
                    if (tick < now) begin
                        push_beat(ST_BAD_ARG, 0, '0, '0, '0, 1);
                        return;
                    end
                    k = 0;
                    while (count != 0 && k < Cap) begin
                        s = order[0];
                        if (due[s] > tick) break;
                        remove_at(0);
                        active[s] = 0;
                        now = due[s];
                        push_beat(ST_OK, 1, 6'(s), seqs[s], due[s], 0);
                        k++;
                    end
                    now = tick;
                    push_beat(ST_OK, 0, '0, '0, '0, 1);
                end
                default: push_beat(ST_BAD_ARG, 0, '0, '0, '0, 1);
            endcase
        endfunction

        function void check_beat(logic [OutW-1:0] d, logic last);
            t_result e, a;
            a.status = t_status'(d[1:0]); a.fired = d[2]; a.slot = d[8:3];
            a.seq = d[72:9]; a.fdue = d[136:73]; a.nd_valid = d[137];
            a.nd_tick = d[201:138]; a.pending = d[208:202]; a.cur_tick = d[272:209];
            a.last = last;
            if (pending_beats.size() == 0) begin
                $display("%0t: unexpected result beat %h last %b", $time, d, last);
                errors++;
                return;
            end
            e = pending_beats.pop_front();
            if (e != a) begin
                $display("%0t: mismatch expected st=%0d f=%b sl=%0d sq=%h fd=%h nv=%b nd=%h pc=%0d ct=%h l=%b",
                         $time, e.status, e.fired, e.slot, e.seq, e.fdue, e.nd_valid,
                         e.nd_tick, e.pending, e.cur_tick, e.last);
                $display("%0t:          actual   st=%0d f=%b sl=%0d sq=%h fd=%h nv=%b nd=%h pc=%0d ct=%h l=%b",
                         $time, a.status, a.fired, a.slot, a.seq, a.fdue, a.nd_valid,
                         a.nd_tick, a.pending, a.cur_tick, a.last);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk = 0;
    logic             i_rst_n = 0;
    logic             s_tvalid = 0;
    logic             s_tready;
    logic [InW-1:0]   s_tdata = '0;
    logic [1:0]       s_tuser = '0;
    logic             m_tvalid;
    logic             m_tready = 0;
    logic [OutW-1:0]  m_tdata;
    logic             m_tlast;

    timer_queue_scoreboard sb = new();
    bit    idle_off = 0;
    bit    hold_sink = 0;
    int    quiet_cycles = 0;
    // tokens recently handed out, used to build valid cancels
    logic [5:0]  tok_slot[$];
    logic [63:0] tok_seq[$];

    timed_event_priority_queue_top #(.CAPACITY(Cap)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tlast(m_tlast)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // result side: check each accepted beat
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) sb.check_beat(m_tdata, m_tlast);
        if (i_rst_n && ((s_tvalid && s_tready) || (m_tvalid && m_tready))) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= StallLim) begin
            $display("timed_event_priority_queue_top_tb NOT OK");
            $finish;
        end
    end

    // receiver readiness
    always @(negedge i_clk) begin
        if (hold_sink) m_tready <= 0;
        else if (idle_off) m_tready <= 1;
        else m_tready <= ($urandom_range(99) >= 17);
    end

    task automatic send_cmd(t_func fn, logic [63:0] tick, logic [5:0] cslot,
                            logic [63:0] cseq);
        if (!idle_off)
            while ($urandom_range(99) < 17) begin
                s_tvalid <= 0;
                @(negedge i_clk);
            end
        s_tvalid <= 1;
        s_tuser  <= fn;
        s_tdata  <= {2'b0, cseq, cslot, tick};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.note_command(fn, tick, cslot, cseq);
        // remember tokens from the model's schedule result
        if (fn == FN_SCHEDULE && sb.pending_beats[$].status == ST_OK) begin
            tok_slot.push_back(sb.pending_beats[$].slot);
            tok_seq.push_back(sb.pending_beats[$].seq);
            if (tok_slot.size() > 24) begin
                void'(tok_slot.pop_front()); void'(tok_seq.pop_front());
            end
        end
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic random_cmd();
        int unsigned p, k;
        logic [63:0] t;
        p = $urandom_range(99);
        if (p < 45) begin
            t = ($urandom_range(9) == 0) ? rand64() : sb.now + $urandom_range(200);
            send_cmd(FN_SCHEDULE, t, 6'($urandom), rand64());
        end else if (p < 70) begin
            if (tok_slot.size() != 0 && $urandom_range(3) != 0) begin
                k = $urandom_range(tok_slot.size() - 1);
                send_cmd(FN_CANCEL, rand64(), tok_slot[k], tok_seq[k]);
            end else
                send_cmd(FN_CANCEL, rand64(), 6'($urandom), rand64());
        end else if (p < 95) begin
            t = ($urandom_range(19) == 0) ? rand64() : sb.now + $urandom_range(150);
            if ($urandom_range(15) == 0) t = sb.now - 1;
            send_cmd(FN_ADVANCE, t, 6'($urandom), rand64());
        end else
            send_cmd(FN_UNUSED, rand64(), 6'($urandom), rand64());
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        // directed: extremes, every func, each error path
        send_cmd(FN_ADVANCE, 64'd0, 6'd0, 64'd0);
        send_cmd(FN_CANCEL, 64'd0, 6'd63, '1);
        send_cmd(FN_CANCEL, '1, 6'd16, 64'd0);
        send_cmd(FN_CANCEL, 64'd0, 6'd0, 64'd0);
        send_cmd(FN_UNUSED, '1, 6'd63, '1);
        for (int i = 0; i < 17; i++) send_cmd(FN_SCHEDULE, 64'(100 - (i % 5)), 6'd0, 64'd0);
        send_cmd(FN_CANCEL, 64'd0, 6'd3, 64'd3);
        send_cmd(FN_CANCEL, 64'd0, 6'd3, 64'd3);
        send_cmd(FN_ADVANCE, 64'd200, 6'd0, 64'd0);
        send_cmd(FN_SCHEDULE, 64'd5, 6'd0, 64'd0);
        send_cmd(FN_ADVANCE, 64'd150, 6'd0, 64'd0);
        // random, with a stretch of no idling and a long receiver hold-off
        for (int n = 0; n < 250; n++) begin
            idle_off = (n >= 60 && n < 110);
            if (n == 150) begin
                fork
                    begin
                        hold_sink = 1;
                        repeat (400) @(negedge i_clk);
                        hold_sink = 0;
                    end
                join_none
            end
            random_cmd();
        end
        send_cmd(FN_SCHEDULE, '1, 6'd0, 64'd0);
        send_cmd(FN_ADVANCE, '1, 6'd0, 64'd0);
        send_cmd(FN_SCHEDULE, '1, 6'd0, 64'd0);
        send_cmd(FN_ADVANCE, '1, 6'd0, 64'd0);
        s_tvalid <= 0;
        while (sb.pending_beats.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_beats.size() == 0)
            $display("timed_event_priority_queue_top_tb OK");
        else
            $display("timed_event_priority_queue_top_tb NOT OK");
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
rtl/tepq_pkg.sv
rtl/tepq_ctrl.sv
rtl/tepq_dp.sv
rtl/timed_event_priority_queue_top.sv
rtl/tepq_checker.sv
test/timed_event_priority_queue_top_tb.sv
